@@ hdl/ppf_pkg.sv @@
// Shared types and constants for the polygon pressure force block.
package ppf_pkg;

  localparam int unsigned XW = 32;
  localparam int unsigned QBITS = 33;
  localparam int unsigned DIV_CW = 6;
  localparam logic [XW-1:0] GAIN_RESET = 32'h0001_0000;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_VOL = 2'd1;
  localparam logic [1:0] ST_FEW_PTS = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLOSE,
    S_DRAIN,
    S_STAT,
    S_READ,
    S_DIFF,
    S_MAG,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } ppf_state_t;

  typedef struct packed {
    logic take;
    logic cfg_wr;
    logic close_mul;
    logic latch_stat;
    logic rd;
    logic diff;
    logic mag;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_init;
    logic div_step;
    logic out_load;
    logic next_k;
    logic clear;
  } ppf_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_k;
    logic out_free;
  } ppf_sts_t;

endpackage

@@ hdl/ppf_ctrl.sv @@
// Controller state machine sequencing load, area close and per-vertex force computation.
module ppf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_vertex,
  input  logic              cfg_valid,
  input  ppf_pkg::ppf_sts_t sts,
  output logic              in_stall,
  output logic              cfg_ready,
  output ppf_pkg::ppf_cmd_t cmd
);

  ppf_pkg::ppf_state_t state_r, state_nxt;
  logic [ppf_pkg::DIV_CW-1:0] div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ppf_pkg::S_LOAD;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    case (state_r)
      ppf_pkg::S_LOAD: begin
        cmd.take   = in_valid;
        cmd.cfg_wr = cfg_valid;
        if (in_valid && in_last_vertex) state_nxt = ppf_pkg::S_CLOSE;
      end
      ppf_pkg::S_CLOSE: begin
        cmd.close_mul = 1'b1;
        state_nxt     = ppf_pkg::S_DRAIN;
      end
      ppf_pkg::S_DRAIN: begin
        if (!sts.busy) state_nxt = ppf_pkg::S_STAT;
      end
      ppf_pkg::S_STAT: begin
        cmd.latch_stat = 1'b1;
        state_nxt      = ppf_pkg::S_READ;
      end
      ppf_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ppf_pkg::S_DIFF;
      end
      ppf_pkg::S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ppf_pkg::S_MAG;
      end
      ppf_pkg::S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ppf_pkg::S_MUL_LO;
      end
      ppf_pkg::S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ppf_pkg::S_MUL_HI;
      end
      ppf_pkg::S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ppf_pkg::S_SUM;
      end
      ppf_pkg::S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ppf_pkg::S_DIV_INIT;
      end
      ppf_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = ppf_pkg::DIV_CW'(ppf_pkg::QBITS - 1);
        state_nxt    = ppf_pkg::S_DIV;
      end
      ppf_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == '0) state_nxt = ppf_pkg::S_OUT;
        else div_cnt_nxt = div_cnt_r - ppf_pkg::DIV_CW'(1);
      end
      ppf_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_k) begin
            cmd.clear = 1'b1;
            state_nxt = ppf_pkg::S_LOAD;
          end else begin
            cmd.next_k = 1'b1;
            state_nxt  = ppf_pkg::S_READ;
          end
        end
      end
      default: state_nxt = ppf_pkg::S_LOAD;
    endcase
  end

  assign in_stall  = (state_r != ppf_pkg::S_LOAD);
  assign cfg_ready = (state_r == ppf_pkg::S_LOAD);

endmodule

@@ hdl/ppf_lane.sv @@
// One force axis: magnitude, split 64x33 multiply, restoring divide and saturation.
module ppf_lane (
  input  logic                     clk,
  input  ppf_pkg::ppf_cmd_t        cmd,
  input  logic signed [31:0]       op_a,
  input  logic signed [31:0]       op_b,
  input  logic [63:0]              mp,
  input  logic [64:0]              dsor,
  input  logic                     area_neg,
  output logic signed [31:0]       force_val
);

  logic signed [32:0] diff_r, diff_nxt;
  logic [32:0] dm_r, dm_nxt;
  logic        neg_r;
  logic [64:0] pp_lo_r, pp_lo_nxt;
  logic [64:0] pp_hi_r, pp_hi_nxt;
  logic [96:0] prod_r, prod_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [32:0] low_r;
  logic [32:0] q_r;
  logic        ovf_r, ovf_nxt;
  logic [65:0] r2, rsub;
  logic        ge;
  logic [32:0] limit;
  logic        sat;
  logic [31:0] mag32;

  assign diff_nxt  = {op_a[31], op_a} - {op_b[31], op_b};
  assign dm_nxt    = diff_r[32] ? (~diff_r + 33'sd1) : diff_r;
  assign pp_lo_nxt = mp[31:0] * dm_r;
  assign pp_hi_nxt = mp[63:32] * dm_r;
  assign prod_nxt  = {32'd0, pp_lo_r} + {pp_hi_r, 32'd0};
  assign ovf_nxt   = ({1'b0, prod_r[96:33]} >= dsor);

  assign r2      = {rem_r, low_r[32]};
  assign rsub    = r2 - {1'b0, dsor};
  assign ge      = (r2 >= {1'b0, dsor});
  assign rem_nxt = ge ? rsub[64:0] : r2[64:0];

  always_ff @(posedge clk) begin
    if (cmd.diff) diff_r <= diff_nxt;
    if (cmd.mag) begin
      dm_r  <= dm_nxt;
      neg_r <= diff_r[32] ^ area_neg;
    end
    if (cmd.mul_lo) pp_lo_r <= pp_lo_nxt;
    if (cmd.mul_hi) pp_hi_r <= pp_hi_nxt;
    if (cmd.sum) prod_r <= prod_nxt;
    if (cmd.div_init) begin
      ovf_r <= ovf_nxt;
      rem_r <= {1'b0, prod_r[96:33]};
      low_r <= prod_r[32:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[31:0], 1'b0};
      q_r   <= {q_r[31:0], ge};
    end
  end

  assign limit     = neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign sat       = ovf_r || (q_r > limit);
  assign mag32     = sat ? limit[31:0] : q_r[31:0];
  assign force_val = neg_r ? (~mag32 + 32'd1) : mag32;

endmodule

@@ hdl/ppf_dp.sv @@
// Datapath: vertex stores, shoelace accumulator, two force lanes and the result register.
module ppf_dp #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppf_pkg::ppf_cmd_t   cmd,
  output ppf_pkg::ppf_sts_t   sts,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic [31:0]         in_inv_mass,
  input  logic [31:0]         cfg_pressure_gain,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  out_force_x,
  output logic signed [31:0]  out_force_y,
  output logic [1:0]          out_status,
  output logic                out_last_force
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  logic signed [31:0] mem_x [MAX_VERTICES];
  logic signed [31:0] mem_y [MAX_VERTICES];
  logic [31:0]        mem_m [MAX_VERTICES];

  logic [CW-1:0] count_r;
  logic [CW-1:0] n_m1;
  logic [AW-1:0] k_r, prev_idx, next_idx;
  logic          store;
  logic [31:0]   gain_r;

  logic signed [31:0] prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic signed [31:0] mul_b, mul_c;
  logic signed [63:0] p1_nxt, p2_nxt, p1_r, p2_r, cross_r;
  logic               pv_r, cv_r, pv_nxt;
  logic signed [63:0] area_r;
  logic signed [64:0] area_sum;
  logic signed [63:0] area_nxt;

  logic [1:0]  stat_r, stat_nxt;
  logic [63:0] abs_area;
  logic [64:0] dsor_r;
  logic        area_neg_r;

  logic signed [31:0] xp_rd_r, xn_rd_r, yp_rd_r, yn_rd_r;
  logic [31:0]        inv_rd_r;
  logic [63:0]        mp_r;
  logic signed [31:0] fx, fy;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] force_x_r, force_y_r;
  logic [1:0]         status_r;
  logic               last_r;

  assign store  = cmd.take && (count_r < CW'(MAX_VERTICES));
  assign n_m1   = count_r - CW'(1);
  assign sts.last_k   = (CW'(k_r) == n_m1);
  assign prev_idx     = (k_r == '0) ? n_m1[AW-1:0] : k_r - AW'(1);
  assign next_idx     = sts.last_k ? '0 : k_r + AW'(1);
  assign sts.busy     = pv_r || cv_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= ppf_pkg::GAIN_RESET;
    else if (cmd.cfg_wr) gain_r <= cfg_pressure_gain;
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem_x[count_r[AW-1:0]] <= in_pos_x;
      mem_y[count_r[AW-1:0]] <= in_pos_y;
      mem_m[count_r[AW-1:0]] <= in_inv_mass;
    end
    if (cmd.rd) begin
      xp_rd_r  <= mem_x[prev_idx];
      xn_rd_r  <= mem_x[next_idx];
      yp_rd_r  <= mem_y[prev_idx];
      yn_rd_r  <= mem_y[next_idx];
      inv_rd_r <= mem_m[k_r];
    end
  end

  // shoelace pipe: products, cross term, saturating accumulate
  assign mul_b  = cmd.close_mul ? first_y_r : in_pos_y;
  assign mul_c  = cmd.close_mul ? first_x_r : in_pos_x;
  assign p1_nxt = prev_x_r * mul_b;
  assign p2_nxt = mul_c * prev_y_r;
  assign pv_nxt = (store && (count_r != '0)) || cmd.close_mul;

  assign area_sum = {area_r[63], area_r} + {cross_r[63], cross_r};
  always_comb begin
    if (area_sum[64] != area_sum[63])
      area_nxt = area_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      area_nxt = area_sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (store) begin
      prev_x_r <= in_pos_x;
      prev_y_r <= in_pos_y;
      if (count_r == '0) begin
        first_x_r <= in_pos_x;
        first_y_r <= in_pos_y;
      end
    end
    if (pv_nxt) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (pv_r) cross_r <= p1_r - p2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      area_r  <= '0;
      pv_r    <= 1'b0;
      cv_r    <= 1'b0;
      k_r     <= '0;
    end else begin
      pv_r <= pv_nxt;
      cv_r <= pv_r;
      if (cmd.clear) begin
        count_r <= '0;
        area_r  <= '0;
        k_r     <= '0;
      end else begin
        if (store) count_r <= count_r + CW'(1);
        if (cv_r) area_r <= area_nxt;
        if (cmd.next_k) k_r <= k_r + AW'(1);
      end
    end
  end

  // polygon status and divisor
  assign abs_area = area_r[63] ? (~area_r + 64'sd1) : area_r;
  always_comb begin
    if (count_r < CW'(3)) stat_nxt = ppf_pkg::ST_FEW_PTS;
    else if (area_r == '0) stat_nxt = ppf_pkg::ST_ZERO_VOL;
    else stat_nxt = ppf_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_stat) begin
      stat_r     <= stat_nxt;
      dsor_r     <= {abs_area, 1'b0};
      area_neg_r <= area_r[63];
    end
    if (cmd.diff) mp_r <= inv_rd_r * gain_r;
  end

  ppf_lane u_lane_x (
    .clk       (clk),
    .cmd       (cmd),
    .op_a      (yn_rd_r),
    .op_b      (yp_rd_r),
    .mp        (mp_r),
    .dsor      (dsor_r),
    .area_neg  (area_neg_r),
    .force_val (fx)
  );

  ppf_lane u_lane_y (
    .clk       (clk),
    .cmd       (cmd),
    .op_a      (xp_rd_r),
    .op_b      (xn_rd_r),
    .mp        (mp_r),
    .dsor      (dsor_r),
    .area_neg  (area_neg_r),
    .force_val (fy)
  );

  // result register
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      force_x_r <= (stat_r == ppf_pkg::ST_OK) ? fx : '0;
      force_y_r <= (stat_r == ppf_pkg::ST_OK) ? fy : '0;
      status_r  <= stat_r;
      last_r    <= sts.last_k;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_force_x    = force_x_r;
  assign out_force_y    = force_y_r;
  assign out_status     = status_r;
  assign out_last_force = last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_area_final: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !(pv_r || cv_r))
    else $error("emit started before area settled");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0 && area_r == '0 && k_r == '0))
    else $error("polygon state not cleared");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_stat |-> (count_r != '0))
    else $error("polygon closed with no stored vertex");

endmodule

@@ hdl/polygon_pressure_force_top.sv @@
// Top level of the polygon pressure force block.
// Vertices of one closed polygon load one per cycle while in_stall is low; the shoelace
// area sum runs in a three-stage pipe beside the load. After the flagged last vertex the
// block closes and settles the area, then computes one vertex's force at a time through
// the split 64x33 multiply and the 33-step restoring divider in each axis lane. Results
// leave through a holding register; the next vertex, or the next polygon's loading after
// the final vertex, starts as soon as the previous result is in that register. Vertices
// beyond MAX_VERTICES are dropped; a dropped vertex still ends the polygon if flagged.
module polygon_pressure_force_top #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [31:0]        in_inv_mass,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic [1:0]         out_status,
  output logic               out_last_force,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_pressure_gain
);

  ppf_pkg::ppf_cmd_t cmd;
  ppf_pkg::ppf_sts_t sts;

  ppf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_vertex (in_last_vertex),
    .cfg_valid      (cfg_valid),
    .sts            (sts),
    .in_stall       (in_stall),
    .cfg_ready      (cfg_ready),
    .cmd            (cmd)
  );

  ppf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_inv_mass       (in_inv_mass),
    .cfg_pressure_gain (cfg_pressure_gain),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_force_x       (out_force_x),
    .out_force_y       (out_force_y),
    .out_status        (out_status),
    .out_last_force    (out_last_force)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the polygon pressure force block: directed and random polygons.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD = 10;
  localparam int MAX_VERTS = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES = 60;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 47;
  localparam int N_ROWS = 21;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;
  localparam logic signed [63:0] AREA_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] AREA_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        inv_mass;
    logic               last;
    logic               pinned;
    logic [1:0]         pinned_status;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic [1:0]         status;
    logic               last;
  } force_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic [31:0]        in_inv_mass;
  logic               in_last_vertex;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_force_x;
  logic signed [31:0] out_force_y;
  logic [1:0]         out_status;
  logic               out_last_force;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_pressure_gain;

  logic signed [31:0] poly_x [MAX_VERTS];
  logic signed [31:0] poly_y [MAX_VERTS];
  logic [31:0]        poly_m [MAX_VERTS];
  logic signed [63:0] area2 = '0;
  int                 poly_len = 0;
  logic [31:0]        gain_shadow = ppf_pkg::GAIN_RESET;
  force_t             pending_forces [$];
  int                 fail_count = 0;
  bit                 gaps_on = 1'b1;
  int                 hold_asks = 0;
  int                 hold_done = 0;

  vertex_t stim_table [N_ROWS] = '{
    '{PMAX, PMIN, 32'hFFFF_FFFF, 1'b1, 1'b1, ppf_pkg::ST_FEW_PTS},
    '{PMIN, PMAX, 32'h0000_0000, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0, 32'sh0, ONE, 1'b1, 1'b1, ppf_pkg::ST_FEW_PTS},
    '{32'sh0, 32'sh0, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{ONE, ONE, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0002_0000, 32'sh0002_0000, ONE, 1'b1, 1'b1, ppf_pkg::ST_ZERO_VOL},
    '{32'sh0, 32'sh0, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{ONE, 32'sh0, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{ONE, 32'sh0, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{ONE, ONE, 32'h0000_8000, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0, ONE, 32'h0002_0000, 1'b1, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0, 32'sh0, 32'hFFFF_FFFF, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0, 32'sh0003_0000, 32'h0000_0001, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0004_0000, 32'sh0, 32'h7FFF_FFFF, 1'b1, 1'b0, ppf_pkg::ST_OK},
    '{PMAX, PMIN, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{PMAX, PMAX, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{PMIN, PMAX, ONE, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{PMIN, PMIN, ONE, 1'b1, 1'b0, ppf_pkg::ST_OK},
    '{32'sh0, 32'sh0, 32'hFFFF_FFFF, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{PMAX, 32'sh1, 32'hFFFF_FFFF, 1'b0, 1'b0, ppf_pkg::ST_OK},
    '{PMAX, 32'sh0, 32'hFFFF_FFFF, 1'b1, 1'b0, ppf_pkg::ST_OK}
  };

  polygon_pressure_force_top #(
    .MAX_VERTICES(MAX_VERTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_inv_mass      (in_inv_mass),
    .in_last_vertex   (in_last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y),
    .out_status       (out_status),
    .out_last_force   (out_last_force),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pressure_gain(cfg_pressure_gain)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) return s[64] ? AREA_MIN : AREA_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] cross_term(input int i, input int j);
    logic signed [65:0] t;
    t = poly_x[i] * poly_y[j] - poly_x[j] * poly_y[i];
    return t[63:0];
  endfunction

  // trunc(mp * diff / (2 * area)), saturated to signed 32 bits
  function automatic logic signed [31:0] scaled_force(input logic [63:0] mp,
                                                      input logic signed [32:0] diff,
                                                      input logic signed [63:0] area);
    logic         neg;
    logic [32:0]  dm;
    logic [63:0]  am;
    logic [129:0] num;
    logic [129:0] den;
    logic [129:0] q;
    logic [129:0] lim;
    logic [31:0]  mag;
    neg = (diff < 0) != (area < 0);
    dm = diff < 0 ? -diff : diff;
    am = area < 0 ? -area : area;
    num = {66'b0, mp} * {97'b0, dm};
    den = {65'b0, am, 1'b0};
    q = num / den;
    lim = neg ? 130'h8000_0000 : 130'h7FFF_FFFF;
    if (q > lim) q = lim;
    mag = q[31:0];
    return neg ? -mag : mag;
  endfunction

  function automatic void emit_forces(input logic pinned, input logic [1:0] pinned_status);
    force_t             f;
    int                 k;
    int                 pv;
    int                 nx;
    logic [63:0]        mp;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [1:0]         st;
    area2 = add_sat(area2, cross_term(poly_len - 1, 0));
    if (poly_len < 3) st = ppf_pkg::ST_FEW_PTS;
    else if (area2 == 0) st = ppf_pkg::ST_ZERO_VOL;
    else st = ppf_pkg::ST_OK;
    for (k = 0; k < poly_len; k++) begin
      f.fx = '0;
      f.fy = '0;
      f.status = st;
      f.last = (k == poly_len - 1);
      if (st == ppf_pkg::ST_OK) begin
        pv = (k == 0) ? poly_len - 1 : k - 1;
        nx = (k == poly_len - 1) ? 0 : k + 1;
        mp = {32'b0, poly_m[k]} * {32'b0, gain_shadow};
        dy = poly_y[nx] - poly_y[pv];
        dx = poly_x[pv] - poly_x[nx];
        f.fx = scaled_force(mp, dy, area2);
        f.fy = scaled_force(mp, dx, area2);
      end
      if (pinned) begin
        f.fx = '0;
        f.fy = '0;
        f.status = pinned_status;
      end
      pending_forces = {pending_forces, f};
    end
    area2 = '0;
    poly_len = 0;
  endfunction

  function automatic void load_vertex(input vertex_t v);
    if (poly_len < MAX_VERTS) begin
      poly_x[poly_len] = v.pos_x;
      poly_y[poly_len] = v.pos_y;
      poly_m[poly_len] = v.inv_mass;
      if (poly_len > 0) area2 = add_sat(area2, cross_term(poly_len - 1, poly_len));
      poly_len++;
    end
    if (v.last) emit_forces(v.pinned, v.pinned_status);
  endfunction

  task automatic send_vertex(input vertex_t v);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= v.pos_x;
    in_pos_y <= v.pos_y;
    in_inv_mass <= v.inv_mass;
    in_last_vertex <= v.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_vertex(v);
  endtask

  task automatic send_polygon(input int n);
    vertex_t v;
    int      shape;
    int      sh;
    int      a;
    int      b;
    int      t;
    int      k;
    int      r;
    shape = $urandom_range(0, 99);
    sh = $urandom_range(4, 24);
    a = int'($urandom_range(0, 2046)) - 1023;
    b = int'($urandom_range(0, 2046)) - 1023;
    v = '0;
    for (k = 0; k < n; k++) begin
      if (k == 0 || $urandom_range(0, 9) != 0) begin
        if (shape < 65) begin
          v.pos_x = $signed($urandom) >>> sh;
          v.pos_y = $signed($urandom) >>> sh;
        end else if (shape < 85) begin
          v.pos_x = $urandom;
          v.pos_y = $urandom;
        end else begin
          t = int'($urandom_range(0, 2046)) - 1023;
          v.pos_x = a * t;
          v.pos_y = b * t;
        end
      end
      r = $urandom_range(0, 9);
      if (r < 4) v.inv_mass = $urandom;
      else if (r < 8) v.inv_mass = $urandom_range(0, 32'h0004_0000);
      else if (r == 8) v.inv_mass = '0;
      else v.inv_mass = 32'hFFFF_FFFF;
      v.last = (k == n - 1);
      send_vertex(v);
    end
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 1;
    if (r == 1) return 2;
    if (r < 4) return $urandom_range(11, 20);
    return $urandom_range(3, 10);
  endfunction

  function automatic logic [31:0] phase_gain(input int ph);
    case (ph)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return 32'h0000_0001;
      4: return $urandom_range(32'h0000_8000, 32'h0004_0000);
      default: return ppf_pkg::GAIN_RESET;
    endcase
  endfunction

  task automatic write_gain(input logic [31:0] g);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_pressure_gain <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain_shadow = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_forces();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_stall
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    force_t got;
    force_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_force_x, out_force_y, out_status, out_last_force};
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected transfer fx=%h fy=%h status=%0d last=%b",
                 $time, got.fx, got.fy, got.status, got.last);
        fail_count++;
      end else begin
        want = pending_forces.pop_front();
        if (got !== want) begin
          $display("%0t: force mismatch: expected fx=%h fy=%h status=%0d last=%b",
                   $time, want.fx, want.fy, want.status, want.last);
          $display("%0t:                 actual   fx=%h fy=%h status=%0d last=%b",
                   $time, got.fx, got.fy, got.status, got.last);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : main
    int  i;
    int  ph;
    int  count;
    int  n;
    bit  held;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_inv_mass = '0;
    in_last_vertex = 1'b0;
    cfg_valid = 1'b0;
    cfg_pressure_gain = '0;
    held = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_ROWS; i++) send_vertex(stim_table[i]);
    drain_forces();

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_gain(phase_gain(ph));
      gaps_on = (ph != N_PHASES - 1);
      if (ph == 2) begin
        send_polygon(MAX_VERTS);
        send_polygon(MAX_VERTS + 3);
      end
      count = 0;
      while (count < PHASE_ITEMS) begin
        n = pick_size();
        send_polygon(n);
        count += n;
        if (ph == 1 && !held) begin
          hold_asks++;
          held = 1'b1;
        end
      end
      drain_forces();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
